[design/jsu_pkg.sv]
// shared types, codes and decode helpers for the json string unescaper
`default_nettype none

package jsu_pkg;

   localparam int unsigned MAX_RESULTS = 4;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_CLOSED = 2'd1;
   localparam logic [1:0] KIND_UNTERM = 2'd2;
   localparam logic [1:0] KIND_BADESC = 2'd3;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_U         = 8'h75;

   localparam logic [15:0] CP_ONE_MAX = 16'h007F;
   localparam logic [15:0] CP_TWO_MAX = 16'h07FF;
   localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
   localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
   localparam logic [7:0]  UTF_CONT   = 8'h80;
   localparam logic [7:0]  MASK_CONT  = 8'h3F;
   localparam logic [7:0]  MASK_LEAD2 = 8'h1F;
   localparam logic [7:0]  MASK_LEAD3 = 8'h0F;

   typedef enum logic [6:0] {
      MODE_BODY = 7'b0000001,
      MODE_ESC  = 7'b0000010,
      MODE_HEX1 = 7'b0000100,
      MODE_HEX2 = 7'b0001000,
      MODE_HEX3 = 7'b0010000,
      MODE_HEX4 = 7'b0100000,
      MODE_SKIP = 7'b1000000
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic       out_last;
   } rsp_payload_type;

   // bit 4 flags a valid digit
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

   // bit 8 flags a known single byte escape
   function automatic logic [8:0] escape_byte(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         CHAR_QUOTE:     r = {1'b1, CHAR_QUOTE};
         CHAR_BACKSLASH: r = {1'b1, CHAR_BACKSLASH};
         CHAR_SLASH:     r = {1'b1, CHAR_SLASH};
         8'h62:          r = {1'b1, 8'h08};
         8'h66:          r = {1'b1, 8'h0C};
         8'h6E:          r = {1'b1, 8'h0A};
         8'h72:          r = {1'b1, 8'h0D};
         8'h74:          r = {1'b1, 8'h09};
         default:        r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

[design/json_string_unescaper_top.sv]
// json string body unescaper: one byte in, up to four results out
// the results of an item go first into the result list register, then one at a time into the rsp_ register
// throughput: one item per cycle while each item gives at most one result and rsp_stall is low;
// an item that gives several results holds req_ stalled until its last result moves into the single
// rsp_ register; items that give no result never stall req_
// reset: synchronous, empties the result list, clears the output valid flag and the hex accumulator, parse mode to body
`default_nettype none

module json_string_unescaper_top
   import jsu_pkg::*;
(
   input  wire             clock,
   input  wire             reset,
   input  wire             req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  wire             rsp_stall,
   output rsp_payload_type rsp_data
);

   mode_type        mode_ff, mode_in;
   logic [11:0]     accum_ff, accum_in;
   rsp_payload_type list_ff [MAX_RESULTS];
   rsp_payload_type gen [MAX_RESULTS];
   logic [2:0]      left_ff, left_in;
   logic [1:0]      idx_ff, idx_in;
   logic [2:0]      gen_cnt;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        out_free, drain, accept, open_end;
   logic [7:0]  b;
   logic [4:0]  hv;
   logic [8:0]  ev;
   logic [15:0] cp;

   assign b        = req_data.in_byte;
   assign hv       = hex_value(b);
   assign ev       = escape_byte(b);
   assign cp       = {accum_ff, hv[3:0]};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign drain    = out_free && (left_ff != 3'd0);
   assign req_stall = !((left_ff == 3'd0) || (drain && left_ff == 3'd1));
   assign accept   = req_valid && !req_stall;

   // decode one byte into its result list
   always_comb begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         gen[i] = '0;
      end
      gen_cnt  = 3'd0;
      mode_in  = mode_ff;
      accum_in = accum_ff;
      open_end = 1'b0;
      case (mode_ff)
         MODE_BODY: begin
            if (b == CHAR_QUOTE) begin
               gen[gen_cnt[1:0]].kind = KIND_CLOSED;
               gen_cnt = gen_cnt + 3'd1;
               mode_in = MODE_SKIP;
            end else if (b == CHAR_BACKSLASH) begin
               mode_in  = MODE_ESC;
               open_end = 1'b1;
            end else begin
               gen[gen_cnt[1:0]].out_byte = b;
               gen_cnt  = gen_cnt + 3'd1;
               open_end = 1'b1;
            end
         end
         MODE_ESC: begin
            if (b == CHAR_U) begin
               accum_in = '0;
               mode_in  = MODE_HEX1;
               if (req_data.in_last) begin
                  gen[gen_cnt[1:0]].kind = KIND_BADESC;
                  gen_cnt = gen_cnt + 3'd1;
               end
            end else begin
               if (ev[8]) begin
                  gen[gen_cnt[1:0]].out_byte = ev[7:0];
                  gen_cnt = gen_cnt + 3'd1;
               end
               mode_in  = MODE_BODY;
               open_end = 1'b1;
            end
         end
         MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
            if (!hv[4]) begin
               gen[gen_cnt[1:0]].kind = KIND_BADESC;
               gen_cnt = gen_cnt + 3'd1;
               mode_in = MODE_SKIP;
            end else begin
               accum_in = {accum_ff[7:0], hv[3:0]};
               mode_in  = (mode_ff == MODE_HEX1) ? MODE_HEX2 :
                          (mode_ff == MODE_HEX2) ? MODE_HEX3 : MODE_HEX4;
               if (req_data.in_last) begin
                  gen[gen_cnt[1:0]].kind = KIND_BADESC;
                  gen_cnt = gen_cnt + 3'd1;
               end
            end
         end
         MODE_HEX4: begin
            if (!hv[4]) begin
               gen[gen_cnt[1:0]].kind = KIND_BADESC;
               gen_cnt = gen_cnt + 3'd1;
               mode_in = MODE_SKIP;
            end else begin
               if (cp <= CP_ONE_MAX) begin
                  gen[0].out_byte = cp[7:0];
                  gen_cnt = 3'd1;
               end else if (cp <= CP_TWO_MAX) begin
                  gen[0].out_byte = UTF_LEAD2 | ({2'b00, cp[11:6]} & MASK_LEAD2);
                  gen[1].out_byte = UTF_CONT | ({2'b00, cp[5:0]} & MASK_CONT);
                  gen_cnt = 3'd2;
               end else begin
                  gen[0].out_byte = UTF_LEAD3 | ({4'h0, cp[15:12]} & MASK_LEAD3);
                  gen[1].out_byte = UTF_CONT | ({2'b00, cp[11:6]} & MASK_CONT);
                  gen[2].out_byte = UTF_CONT | ({2'b00, cp[5:0]} & MASK_CONT);
                  gen_cnt = 3'd3;
               end
               mode_in  = MODE_BODY;
               open_end = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (req_data.in_last) begin
         if (open_end) begin
            gen[gen_cnt[1:0]].kind = KIND_UNTERM;
            gen_cnt = gen_cnt + 3'd1;
         end
         mode_in  = MODE_BODY;
         accum_in = '0;
      end
      for (int i = 0; i < MAX_RESULTS; i++) begin
         gen[i].out_last = (3'(i) == gen_cnt - 3'd1);
      end
   end

   // result list and output register
   always_comb begin
      left_in      = left_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (drain) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = list_ff[idx_ff];
         left_in      = left_ff - 3'd1;
         idx_in       = idx_ff + 2'd1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         left_in = gen_cnt;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_BODY;
         accum_ff     <= '0;
         left_ff      <= 3'd0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            accum_ff <= accum_in;
         end
         left_ff      <= left_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            list_ff[i] <= gen[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_list_bound: assert property (@(posedge clock) disable iff (reset)
      left_ff <= 3'(MAX_RESULTS))
      else $error("result list holds more than four entries");

   a_list_index: assert property (@(posedge clock) disable iff (reset)
      left_ff != 3'd0 |-> (3'(idx_ff) + left_ff) <= 3'(MAX_RESULTS))
      else $error("result list index runs past its entries");

   a_last_body: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.in_last |=> mode_ff == MODE_BODY && accum_ff == '0)
      else $error("parser not back in body mode after a last byte");

   a_kind_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.kind == KIND_DATA || rsp_data_ff.out_byte == 8'h00))
      else $error("non-data result carries a byte");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && left_ff == 3'd0)
      else $error("output not idle after reset");

endmodule

`default_nettype wire

[test/json_string_unescaper_top_tb.sv]
// self-checking testbench for the json string unescaper top level
`timescale 1ns / 1ps

module json_string_unescaper_top_tb;
   import jsu_pkg::*;

   localparam int RANDOM_ITEMS = 130;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 120;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_A_UP = 8'h41;
   localparam logic [7:0] CH_F_UP = 8'h46;
   localparam logic [7:0] CH_A_LO = 8'h61;
   localparam logic [7:0] CH_B    = 8'h62;
   localparam logic [7:0] CH_F    = 8'h66;
   localparam logic [7:0] CH_G    = 8'h67;
   localparam logic [7:0] CH_N    = 8'h6E;
   localparam logic [7:0] CH_Q    = 8'h71;
   localparam logic [7:0] CH_R    = 8'h72;
   localparam logic [7:0] CH_T    = 8'h74;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_Z    = 8'h7A;

   class unescape_scoreboard;
      rsp_payload_type expected_out[$];
      mode_type        mode;
      logic [15:0]     code;
      int              mismatches;
      int              items_seen;

      function new();
         mode = MODE_BODY;
         code = '0;
         mismatches = 0;
         items_seen = 0;
      endfunction

      function int hex_nibble(logic [7:0] c);
         if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
         end
         if (c >= CH_A_LO && c <= CH_F) begin
            return int'(c - CH_A_LO) + 10;
         end
         if (c >= CH_A_UP && c <= CH_F_UP) begin
            return int'(c - CH_A_UP) + 10;
         end
         return -1;
      endfunction

      function void add_out(logic [7:0] b, logic [1:0] k);
         rsp_payload_type r;
         r.out_byte = b;
         r.kind     = k;
         r.out_last = 1'b0;
         expected_out = {expected_out, r};
      endfunction

      function void take_byte(req_payload_type item);
         logic [7:0] b;
         logic       open_end;
         int         start;
         int         d;
         b = item.in_byte;
         open_end = 1'b0;
         start = expected_out.size();
         items_seen++;
         case (mode)
            MODE_BODY: begin
               if (b == CHAR_QUOTE) begin
                  add_out(8'h00, KIND_CLOSED);
                  mode = MODE_SKIP;
               end else if (b == CHAR_BACKSLASH) begin
                  mode = MODE_ESC;
                  open_end = 1'b1;
               end else begin
                  add_out(b, KIND_DATA);
                  open_end = 1'b1;
               end
            end
            MODE_ESC: begin
               if (b == CHAR_U) begin
                  code = '0;
                  mode = MODE_HEX1;
                  if (item.in_last) begin
                     add_out(8'h00, KIND_BADESC);
                  end
               end else begin
                  case (b)
                     CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: add_out(b, KIND_DATA);
                     CH_B: add_out(8'h08, KIND_DATA);
                     CH_F: add_out(8'h0C, KIND_DATA);
                     CH_N: add_out(8'h0A, KIND_DATA);
                     CH_R: add_out(8'h0D, KIND_DATA);
                     CH_T: add_out(8'h09, KIND_DATA);
                     default: ;
                  endcase
                  mode = MODE_BODY;
                  open_end = 1'b1;
               end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
               d = hex_nibble(b);
               if (d < 0) begin
                  add_out(8'h00, KIND_BADESC);
                  mode = MODE_SKIP;
               end else begin
                  code = {code[11:0], d[3:0]};
                  if (mode == MODE_HEX4) begin
                     if (code <= CP_ONE_MAX) begin
                        add_out(code[7:0], KIND_DATA);
                     end else if (code <= CP_TWO_MAX) begin
                        add_out(UTF_LEAD2 | {3'b000, code[10:6]}, KIND_DATA);
                        add_out(UTF_CONT | {2'b00, code[5:0]}, KIND_DATA);
                     end else begin
                        add_out(UTF_LEAD3 | {4'b0000, code[15:12]}, KIND_DATA);
                        add_out(UTF_CONT | {2'b00, code[11:6]}, KIND_DATA);
                        add_out(UTF_CONT | {2'b00, code[5:0]}, KIND_DATA);
                     end
                     mode = MODE_BODY;
                     open_end = 1'b1;
                  end else begin
                     mode = mode_type'(mode << 1);
                     if (item.in_last) begin
                        add_out(8'h00, KIND_BADESC);
                     end
                  end
               end
            end
            default: ;
         endcase
         if (item.in_last) begin
            if (open_end) begin
               add_out(8'h00, KIND_UNTERM);
            end
            mode = MODE_BODY;
            code = '0;
         end
         if (expected_out.size() > start) begin
            expected_out[expected_out.size() - 1].out_last = 1'b1;
         end
      endfunction

      function void check_out(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_out.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected result: byte %h kind %0d last %0d",
                        got.out_byte, got.kind, got.out_last);
            end
            return;
         end
         want = expected_out.pop_front();
         if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
             got.out_last !== want.out_last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: want byte %h kind %0d last %0d, got %h kind %0d last %0d",
                        want.out_byte, want.kind, want.out_last,
                        got.out_byte, got.kind, got.out_last);
            end
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   unescape_scoreboard sb = new();

   logic [7:0] source_bytes[$];
   int         useful_items = 0;
   int         burst_left = 0;
   int         hold_left = 0;
   bit         hold_done = 1'b0;
   int         stall_mode = 0;
   int         mode_cycles = 0;
   int         cycle_count = 0;

   json_string_unescaper_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.take_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_out(rsp_data);
         end
      end
   end

   // changing stall pattern, broken once by a long hold after 40 items
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sb.items_seen >= 40) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_cycles == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_cycles <= $urandom_range(20, 80);
         end else begin
            mode_cycles <= mode_cycles - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic last);
      if (burst_left == 0) begin
         if (hold_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= {b, last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic push_byte(input logic [7:0] b, input bit counts);
      source_bytes = {source_bytes, b};
      if (counts) begin
         useful_items++;
      end
   endtask

   task automatic send_source();
      for (int i = 0; i < source_bytes.size(); i++) begin
         send_item(source_bytes[i], i == source_bytes.size() - 1);
      end
      source_bytes.delete();
   endtask

   task automatic add_hex(input logic [15:0] cp, input int count);
      logic [3:0] nib;
      logic [7:0] c;
      for (int i = 0; i < count; i++) begin
         nib = cp[15 - 4 * i -: 4];
         if (nib < 4'd10) begin
            c = CH_ZERO + {4'h0, nib};
         end else begin
            c = (($urandom_range(0, 1) != 0) ? CH_A_LO : CH_A_UP) + {4'h0, nib} - 8'd10;
         end
         push_byte(c, 1'b1);
      end
   endtask

   function automatic logic [15:0] pick_code_point();
      logic [15:0] cp;
      case ($urandom_range(0, 3))
         0: cp = 16'($urandom_range(0, CP_ONE_MAX));
         1: cp = 16'($urandom_range(CP_ONE_MAX + 1, CP_TWO_MAX));
         2: cp = 16'($urandom_range(CP_TWO_MAX + 1, 16'hFFFF));
         default: begin
            case ($urandom_range(0, 5))
               0: cp = 16'h0000;
               1: cp = CP_ONE_MAX;
               2: cp = CP_ONE_MAX + 16'd1;
               3: cp = CP_TWO_MAX;
               4: cp = CP_TWO_MAX + 16'd1;
               default: cp = 16'hFFFF;
            endcase
         end
      endcase
      return cp;
   endfunction

   task automatic add_unit();
      logic [7:0] b;
      int         pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         b = 8'($urandom_range(0, 255));
         if (b == CHAR_QUOTE || b == CHAR_BACKSLASH) begin
            b = b ^ 8'h80;
         end
         push_byte(b, 1'b1);
      end else if (pick < 6) begin
         push_byte(CHAR_BACKSLASH, 1'b1);
         case ($urandom_range(0, 7))
            0: b = CHAR_QUOTE;
            1: b = CHAR_BACKSLASH;
            2: b = CHAR_SLASH;
            3: b = CH_B;
            4: b = CH_F;
            5: b = CH_N;
            6: b = CH_R;
            default: b = CH_T;
         endcase
         push_byte(b, 1'b1);
      end else if (pick < 9) begin
         push_byte(CHAR_BACKSLASH, 1'b1);
         push_byte(CHAR_U, 1'b1);
         add_hex(pick_code_point(), 4);
      end else begin
         push_byte(CHAR_BACKSLASH, 1'b1);
         do begin
            b = 8'($urandom_range(0, 255));
         end while (b == CHAR_U);
         push_byte(b, 1'b1);
      end
   endtask

   task automatic build_source();
      logic [7:0] b;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         repeat ($urandom_range(0, 8)) add_unit();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               push_byte(CHAR_QUOTE, 1'b1);
               repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            6: begin
               if (source_bytes.size() == 0) begin
                  push_byte(CH_A_LO, 1'b1);
               end
            end
            7: push_byte(CHAR_BACKSLASH, 1'b1);
            8: begin
               push_byte(CHAR_BACKSLASH, 1'b1);
               push_byte(CHAR_U, 1'b1);
               add_hex(pick_code_point(), $urandom_range(0, 3));
            end
            default: begin
               push_byte(CHAR_BACKSLASH, 1'b1);
               push_byte(CHAR_U, 1'b1);
               add_hex(pick_code_point(), $urandom_range(0, 3));
               do begin
                  b = 8'($urandom_range(0, 255));
               end while (sb.hex_nibble(b) >= 0);
               push_byte(b, 1'b1);
               repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
            end
         endcase
      end
      send_source();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // byte extremes, unknown escape, two-byte code point, close, discarded tail
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(CHAR_BACKSLASH, 1'b1);
      push_byte(CH_Q, 1'b1);
      push_byte(CHAR_BACKSLASH, 1'b1);
      push_byte(CHAR_U, 1'b1);
      add_hex(16'h07FF, 4);
      push_byte(CHAR_QUOTE, 1'b1);
      push_byte(CH_X, 1'b0);
      send_source();

      // three-byte code point ending the source: four results
      push_byte(CHAR_BACKSLASH, 1'b1);
      push_byte(CHAR_U, 1'b1);
      add_hex(16'hFFFF, 4);
      send_source();

      // bad hex digit, then discard up to last
      push_byte(CHAR_BACKSLASH, 1'b1);
      push_byte(CHAR_U, 1'b1);
      push_byte(CH_ZERO + 8'd1, 1'b1);
      push_byte(CH_G, 1'b1);
      push_byte(CH_Z, 1'b0);
      send_source();

      // source ends right after the u
      push_byte(CHAR_BACKSLASH, 1'b1);
      push_byte(CHAR_U, 1'b1);
      send_source();

      // source ends after a backslash
      push_byte(CHAR_BACKSLASH, 1'b1);
      send_source();

      useful_items = 0;
      while (useful_items < RANDOM_ITEMS) build_source();
      req_valid <= 1'b0;

      while (sb.expected_out.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_out.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[json_string_unescaper_top.f]
design/jsu_pkg.sv
design/json_string_unescaper_top.sv
test/json_string_unescaper_top_tb.sv
